### hdl/fpa_pkg.sv
// Shared types, constants and saturation helpers for the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 8;
  localparam int DIV_W  = WORD_W + FRAC_W;
  localparam int PROD_W = 2 * WORD_W;
  localparam int MAG_W  = PROD_W - FRAC_W;
  localparam int ACT_W  = 4;

  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD     = 4'd0,
    ACT_SUB     = 4'd1,
    ACT_MUL     = 4'd2,
    ACT_DIV     = 4'd3,
    ACT_GT      = 4'd4,
    ACT_LT      = 4'd5,
    ACT_GE      = 4'd6,
    ACT_LE      = 4'd7,
    ACT_EQ      = 4'd8,
    ACT_NE      = 4'd9,
    ACT_INC     = 4'd10,
    ACT_DEC     = 4'd11,
    ACT_MIN     = 4'd12,
    ACT_MAX     = 4'd13,
    ACT_TOINT   = 4'd14,
    ACT_FROMINT = 4'd15
  } action_e;

  // One pipeline slot. divd holds the dividend bits still to be consumed in
  // its upper part and the quotient bits produced so far in its lower part.
  typedef struct packed {
    logic              valid;
    action_e           act;
    logic              neg;
    logic [WORD_W-1:0] res;
    logic              ovf;
    logic              dz;
    logic [PROD_W-1:0] prod;
    logic [DIV_W-1:0]  divd;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] dsr;
  } cell_t;

  // Clamp a sign-extended sum one bit wider than the word.
  function automatic logic [WORD_W:0] sat_ext(input logic [WORD_W:0] v);
    logic ovf;
    ovf = v[WORD_W] ^ v[WORD_W-1];
    if (ovf) begin
      return {1'b1, (v[WORD_W] ? WORD_MIN : WORD_MAX)};
    end
    return {1'b0, v[WORD_W-1:0]};
  endfunction

  // Apply a sign to a magnitude and clamp; returns {overflow, word}.
  function automatic logic [WORD_W:0] sat_mag(input logic [MAG_W-1:0] mag,
                                               input logic neg);
    logic [MAG_W-1:0] lim_neg;
    logic [MAG_W-1:0] lim_pos;
    lim_neg = MAG_W'(WORD_MIN);
    lim_pos = MAG_W'(WORD_MAX);
    if (neg) begin
      if (mag > lim_neg) begin
        return {1'b1, WORD_MIN};
      end
      return {1'b0, WORD_W'(-mag[WORD_W-1:0])};
    end
    if (mag > lim_pos) begin
      return {1'b1, WORD_MAX};
    end
    return {1'b0, mag[WORD_W-1:0]};
  endfunction

endpackage

### hdl/fpa_front.sv
// Entry stage: decodes the item, computes every action but multiply and divide, and the product.
`timescale 1ns / 1ps
module fpa_front
  import fpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [WORD_W-1:0] operand_a_i,
  input  logic [WORD_W-1:0] operand_b_i,
  output cell_t             cell_o
);

  cell_t cell_d, cell_q;

  logic signed [WORD_W-1:0] a_s, b_s;
  logic [WORD_W-1:0] ma, mb;
  logic [WORD_W:0] sum_w, dif_w, inc_w, dec_w;
  logic [FRAC_W:0] top_bits;
  logic fi_ovf;

  always_comb begin
    a_s = $signed(operand_a_i);
    b_s = $signed(operand_b_i);
    ma  = operand_a_i[WORD_W-1] ? WORD_W'(-operand_a_i) : operand_a_i;
    mb  = operand_b_i[WORD_W-1] ? WORD_W'(-operand_b_i) : operand_b_i;
    sum_w = {operand_a_i[WORD_W-1], operand_a_i} + {operand_b_i[WORD_W-1], operand_b_i};
    dif_w = {operand_a_i[WORD_W-1], operand_a_i} - {operand_b_i[WORD_W-1], operand_b_i};
    inc_w = {operand_a_i[WORD_W-1], operand_a_i} + (WORD_W+1)'(1);
    dec_w = {operand_a_i[WORD_W-1], operand_a_i} - (WORD_W+1)'(1);
    top_bits = operand_a_i[WORD_W-1 -: FRAC_W+1];
    fi_ovf = !((&top_bits) || (~|top_bits));

    cell_d       = '0;
    cell_d.valid = valid_i;
    cell_d.act   = action_e'(action_i);
    cell_d.neg   = operand_a_i[WORD_W-1] ^ operand_b_i[WORD_W-1];
    cell_d.prod  = ma * mb;
    cell_d.divd  = {ma, {FRAC_W{1'b0}}};
    cell_d.rem   = '0;
    cell_d.dsr   = mb;

    case (action_e'(action_i))
      ACT_ADD: {cell_d.ovf, cell_d.res} = sat_ext(sum_w);
      ACT_SUB: {cell_d.ovf, cell_d.res} = sat_ext(dif_w);
      ACT_INC: {cell_d.ovf, cell_d.res} = sat_ext(inc_w);
      ACT_DEC: {cell_d.ovf, cell_d.res} = sat_ext(dec_w);
      ACT_GT:  cell_d.res = WORD_W'(a_s > b_s);
      ACT_LT:  cell_d.res = WORD_W'(a_s < b_s);
      ACT_GE:  cell_d.res = WORD_W'(a_s >= b_s);
      ACT_LE:  cell_d.res = WORD_W'(a_s <= b_s);
      ACT_EQ:  cell_d.res = WORD_W'(a_s == b_s);
      ACT_NE:  cell_d.res = WORD_W'(a_s != b_s);
      ACT_MIN: cell_d.res = (a_s < b_s) ? operand_a_i : operand_b_i;
      ACT_MAX: cell_d.res = (a_s > b_s) ? operand_a_i : operand_b_i;
      ACT_TOINT: cell_d.res = WORD_W'(a_s >>> FRAC_W);
      ACT_FROMINT: begin
        cell_d.ovf = fi_ovf;
        if (fi_ovf) begin
          cell_d.res = operand_a_i[WORD_W-1] ? WORD_MIN : WORD_MAX;
        end else begin
          cell_d.res = {operand_a_i[WORD_W-1-FRAC_W:0], {FRAC_W{1'b0}}};
        end
      end
      ACT_DIV: cell_d.dz = (operand_b_i == '0);
      default: cell_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### hdl/fpa_cell.sv
// One restoring division step; every other field of the item passes through.
`timescale 1ns / 1ps
module fpa_cell
  import fpa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cell_t cell_i,
  output cell_t cell_o
);

  cell_t cell_d, cell_q;
  logic [WORD_W:0] trial;
  logic            take;

  always_comb begin
    trial = {cell_i.rem, cell_i.divd[DIV_W-1]};
    take  = trial >= {1'b0, cell_i.dsr};
    cell_d      = cell_i;
    cell_d.rem  = take ? WORD_W'(trial - {1'b0, cell_i.dsr}) : trial[WORD_W-1:0];
    cell_d.divd = {cell_i.divd[DIV_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### hdl/fpa_back.sv
// Exit stage: rounds and saturates multiply and divide, selects and registers the result.
`timescale 1ns / 1ps
module fpa_back
  import fpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  cell_t             cell_i,
  output logic              valid_o,
  output logic [WORD_W-1:0] result_o,
  output logic              overflow_o,
  output logic              divide_error_o
);

  logic              valid_q;
  logic [WORD_W-1:0] result_q, result_d;
  logic              ovf_q, ovf_d, dz_q;
  logic [MAG_W-1:0]  mul_mag, div_mag;
  logic              rnd_up;

  always_comb begin
    // Round half away from zero on the magnitudes.
    mul_mag = MAG_W'((cell_i.prod + PROD_W'(1 << (FRAC_W - 1))) >> FRAC_W);
    rnd_up  = {cell_i.rem, 1'b0} >= {1'b0, cell_i.dsr};
    div_mag = MAG_W'(cell_i.divd) + MAG_W'(rnd_up);
    result_d = cell_i.res;
    ovf_d    = cell_i.ovf;
    case (cell_i.act)
      ACT_MUL: {ovf_d, result_d} = sat_mag(mul_mag, cell_i.neg);
      ACT_DIV: begin
        if (cell_i.dz) begin
          {ovf_d, result_d} = '0;
        end else begin
          {ovf_d, result_d} = sat_mag(div_mag, cell_i.neg);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      result_q <= '0;
      ovf_q    <= 1'b0;
      dz_q     <= 1'b0;
    end else if (en_i) begin
      valid_q  <= cell_i.valid;
      result_q <= result_d;
      ovf_q    <= ovf_d;
      dz_q     <= cell_i.dz && (cell_i.act == ACT_DIV);
    end
  end

  assign valid_o        = valid_q;
  assign result_o       = result_q;
  assign overflow_o     = ovf_q;
  assign divide_error_o = dz_q;

endmodule

### hdl/fixed_point_q24_8_alu.sv
// Top level of the signed Q24.8 fixed-point ALU: entry stage, division chain, exit stage.
//
//   channel   direction  tdata fields (lowest bit first)
//   s_axis    in         action[3:0], operand_a[35:4], operand_b[67:36], pad to 72
//   m_axis    out        result[31:0], overflow[32], divide_error[33], pad to 40
//
// One item is accepted per cycle unless a result waits on m_axis; each item passes
// through one entry stage, a chain of 40 one-bit division cells, one exit stage.
// The chain length is the width of the scaled dividend (word plus fraction bits).
// All stages move together; they hold only while a result waits on m_axis.
// Reset clears the valid bits of every stage.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu
  import fpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // action, operand_a, operand_b, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // result, overflow, divide_error, zero pad
);

  logic              en;
  logic [WORD_W-1:0] result;
  logic              overflow, divide_error;
  cell_t             chain [DIV_W+1];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  fpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s_axis_tvalid),
    .action_i    (s_axis_tdata[ACT_W-1:0]),
    .operand_a_i (s_axis_tdata[ACT_W +: WORD_W]),
    .operand_b_i (s_axis_tdata[ACT_W+WORD_W +: WORD_W]),
    .cell_o      (chain[0])
  );

  for (genvar i = 0; i < DIV_W; i++) begin : g_cell
    fpa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  fpa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .cell_i         (chain[DIV_W]),
    .valid_o        (m_axis_tvalid),
    .result_o       (result),
    .overflow_o     (overflow),
    .divide_error_o (divide_error)
  );

  assign m_axis_tdata = {6'd0, divide_error, overflow, result};

`ifndef SYNTH
  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && divide_error |-> (result == '0) && !overflow)
    else $error("divide error with nonzero result or overflow");

  a_ovf_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && overflow |-> (result == WORD_MAX) || (result == WORD_MIN))
    else $error("overflow flagged on a value that is not a rail");

  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while the pipeline is stalled");
`endif

endmodule
